// File: src/fufe_pkg.sv
// Shared constants, phase codes and helper functions for the form field extractor.
// No dependencies; the core and the testbench take names from here by scoped reference.
package fufe_pkg;

  localparam int MAX_KEY_BYTES = 8;

  localparam int PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_HEAD     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_VALUE    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_ESC1     = 3'd2;
  localparam logic [PHASE_W-1:0] PH_ESC2     = 3'd3;
  localparam logic [PHASE_W-1:0] PH_ESC2_BAD = 3'd4;
  localparam logic [PHASE_W-1:0] PH_SKIP     = 3'd5;
  localparam logic [PHASE_W-1:0] PH_DONE     = 3'd6;
  localparam logic [PHASE_W-1:0] PH_HALT     = 3'd7;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NL      = 8'h0A;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_BAD_HEX = 2'd1;
  localparam logic [1:0] ERR_CUT     = 2'd2;

  localparam logic [1:0] REG_SELECT_MODE = 2'd0;
  localparam logic [1:0] REG_KEY_TEXT    = 2'd1;
  localparam logic [1:0] REG_KEY_LENGTH  = 2'd2;
  localparam logic [1:0] REG_SUPPRESS_NL = 2'd3;

  localparam int ADDR_W = 5;

  typedef struct packed {
    logic       ok;
    logic [3:0] nibble;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.ok = 1'b1;
    h.nibble = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.nibble = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      h.nibble = b[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// File: src/fufe_if.sv
// Stream channel interfaces for the form field extractor: input bytes and results.
// Depends on nothing but the clockless valid/ready handshake.
interface fufe_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_byte;
  modport source (output valid, kind, in_byte, input ready);
  modport sink (input valid, kind, in_byte, output ready);
endinterface

interface fufe_out_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] out_byte;
  logic       stream_end;
  logic [1:0] error_code;
  modport source (output valid, has_byte, out_byte, stream_end, error_code, input ready);
  modport sink (input valid, has_byte, out_byte, stream_end, error_code, output ready);
endinterface

// File: src/form_urlencoded_field_extractor_core.sv
// Top level of the form-urlencoded field extractor: APB registers, byte parser, result register.
// Depends on fufe_pkg and the channel interfaces in fufe_if.sv.

// The block takes one request per clock when the result side keeps up. A request is
// captured in an input register, parsed by a small per-byte state machine once the
// output register is free or being drained, and any result lands in that output
// register; throughput is one byte per cycle while the result side keeps up. Requests
// that produce no output (key bytes in select mode, '%' and the first escape digit)
// still pass through the parser like any other request. Registers sit at byte addresses
// 0, 8, 16 and 24 on a 64-bit APB port; write them only while no stream is in flight.
module form_urlencoded_field_extractor_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fufe_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready,
  fufe_in_if.sink                     din,
  fufe_out_if.source                  dout
);

  logic        select_mode;
  logic [63:0] key_text;
  logic [3:0]  key_length;
  logic        suppress_newline;

  logic        s1_valid;
  logic        s1_kind;
  logic [7:0]  s1_byte;

  logic [fufe_pkg::PHASE_W-1:0] phase, phase_next;
  logic [3:0]  match_position, match_position_next;
  logic [3:0]  high_nibble, high_nibble_next;

  logic        o_valid;
  logic        o_has_byte;
  logic [7:0]  o_byte;
  logic        o_end;
  logic [1:0]  o_err;

  logic        res_valid;
  logic        res_has;
  logic [7:0]  res_byte;
  logic        res_end;
  logic [1:0]  res_err;

  logic        s1_fire;
  logic        cfg_wr;
  logic [1:0]  cfg_sel;
  logic [3:0]  eff_len;
  logic [7:0]  key_byte;
  fufe_pkg::hex_t hx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = paddr[4:3];

  always_comb begin
    case (cfg_sel)
      fufe_pkg::REG_SELECT_MODE: prdata = {63'd0, select_mode};
      fufe_pkg::REG_KEY_TEXT:    prdata = key_text;
      fufe_pkg::REG_KEY_LENGTH:  prdata = {60'd0, key_length};
      fufe_pkg::REG_SUPPRESS_NL: prdata = {63'd0, suppress_newline};
      default:                   prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      select_mode      <= 1'b0;
      key_text         <= 64'd0;
      key_length       <= 4'd0;
      suppress_newline <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        fufe_pkg::REG_SELECT_MODE: select_mode      <= pwdata[0];
        fufe_pkg::REG_KEY_TEXT:    key_text         <= pwdata;
        fufe_pkg::REG_KEY_LENGTH:  key_length       <= pwdata[3:0];
        fufe_pkg::REG_SUPPRESS_NL: suppress_newline <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Stage 1 advances whenever the result register is free or being drained.
  assign s1_fire   = s1_valid && (!o_valid || dout.ready);
  assign din.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (din.ready) begin
      s1_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.ready && din.valid) begin
      s1_kind <= din.kind;
      s1_byte <= din.in_byte;
    end
  end

  assign eff_len  = (key_length > 4'(fufe_pkg::MAX_KEY_BYTES)) ?
                    4'(fufe_pkg::MAX_KEY_BYTES) : key_length;
  assign key_byte = key_text[match_position[2:0]*8 +: 8];
  assign hx       = fufe_pkg::hex_decode(s1_byte);

  always_comb begin
    phase_next          = phase;
    match_position_next = match_position;
    high_nibble_next    = high_nibble;
    res_valid = 1'b0;
    res_has   = 1'b0;
    res_byte  = 8'd0;
    res_end   = 1'b0;
    res_err   = fufe_pkg::ERR_NONE;
    if (s1_kind) begin
      phase_next          = fufe_pkg::PH_HEAD;
      match_position_next = 4'd0;
      high_nibble_next    = 4'd0;
      res_valid = 1'b1;
      res_end   = 1'b1;
      if (phase == fufe_pkg::PH_HALT) begin
        res_err = fufe_pkg::ERR_NONE;
      end else if (phase == fufe_pkg::PH_ESC1 || phase == fufe_pkg::PH_ESC2 ||
                   phase == fufe_pkg::PH_ESC2_BAD) begin
        res_err = fufe_pkg::ERR_CUT;
      end else if (select_mode ? !suppress_newline : (phase == fufe_pkg::PH_VALUE)) begin
        res_has  = 1'b1;
        res_byte = fufe_pkg::CH_NL;
      end
    end else begin
      case (phase)
        fufe_pkg::PH_HEAD: begin
          if (!select_mode) begin
            if (s1_byte == fufe_pkg::CH_EQUAL) phase_next = fufe_pkg::PH_VALUE;
            res_valid = 1'b1;
            res_has   = 1'b1;
            res_byte  = s1_byte;
          end else if (match_position < eff_len) begin
            if (s1_byte == key_byte) begin
              match_position_next = match_position + 4'd1;
            end else if (s1_byte == fufe_pkg::CH_AMP) begin
              match_position_next = 4'd0;
            end else begin
              match_position_next = 4'd0;
              phase_next          = fufe_pkg::PH_SKIP;
            end
          end else begin
            match_position_next = 4'd0;
            if (s1_byte == fufe_pkg::CH_EQUAL) phase_next = fufe_pkg::PH_VALUE;
            else if (s1_byte != fufe_pkg::CH_AMP) phase_next = fufe_pkg::PH_SKIP;
          end
        end
        fufe_pkg::PH_SKIP: begin
          if (s1_byte == fufe_pkg::CH_AMP) begin
            phase_next          = fufe_pkg::PH_HEAD;
            match_position_next = 4'd0;
          end
        end
        fufe_pkg::PH_VALUE: begin
          if (s1_byte == fufe_pkg::CH_AMP) begin
            if (select_mode) begin
              phase_next = fufe_pkg::PH_DONE;
            end else begin
              phase_next          = fufe_pkg::PH_HEAD;
              match_position_next = 4'd0;
              res_valid = 1'b1;
              res_has   = 1'b1;
              res_byte  = fufe_pkg::CH_NL;
            end
          end else if (s1_byte == fufe_pkg::CH_PERCENT) begin
            phase_next = fufe_pkg::PH_ESC1;
          end else begin
            res_valid = 1'b1;
            res_has   = 1'b1;
            res_byte  = (s1_byte == fufe_pkg::CH_PLUS) ? fufe_pkg::CH_SPACE : s1_byte;
          end
        end
        fufe_pkg::PH_ESC1: begin
          high_nibble_next = hx.nibble;
          phase_next = hx.ok ? fufe_pkg::PH_ESC2 : fufe_pkg::PH_ESC2_BAD;
        end
        fufe_pkg::PH_ESC2: begin
          high_nibble_next = 4'd0;
          res_valid = 1'b1;
          if (hx.ok) begin
            phase_next = fufe_pkg::PH_VALUE;
            res_has    = 1'b1;
            res_byte   = {high_nibble, hx.nibble};
          end else begin
            phase_next = fufe_pkg::PH_HALT;
            res_err    = fufe_pkg::ERR_BAD_HEX;
          end
        end
        fufe_pkg::PH_ESC2_BAD: begin
          high_nibble_next = 4'd0;
          phase_next = fufe_pkg::PH_HALT;
          res_valid  = 1'b1;
          res_err    = fufe_pkg::ERR_BAD_HEX;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= fufe_pkg::PH_HEAD;
      match_position <= 4'd0;
      high_nibble    <= 4'd0;
    end else if (s1_fire) begin
      phase          <= phase_next;
      match_position <= match_position_next;
      high_nibble    <= high_nibble_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_fire && res_valid) begin
      o_valid <= 1'b1;
    end else if (dout.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      o_has_byte <= res_has;
      o_byte     <= res_byte;
      o_end      <= res_end;
      o_err      <= res_err;
    end
  end

  assign dout.valid      = o_valid;
  assign dout.has_byte   = o_has_byte;
  assign dout.out_byte   = o_byte;
  assign dout.stream_end = o_end;
  assign dout.error_code = o_err;

endmodule

// File: sim/tb_form_urlencoded_field_extractor_core.sv
`timescale 1ns / 1ps
// Testbench for form_urlencoded_field_extractor_core: drives form streams through the
// request channel, predicts every result and checks the result channel field by field.
// Depends on fufe_pkg, the channel interfaces in fufe_if.sv and the core itself.

typedef struct packed {
  logic       has_byte;
  logic [7:0] out_byte;
  logic       stream_end;
  logic [1:0] error_code;
} fx_result_t;

// {ok, nibble} for one escape digit
function automatic logic [4:0] hex_nibble(input logic [7:0] c);
  logic [7:0] d;
  d = 8'd0;
  if (c >= "0" && c <= "9") begin
    d = c - "0";
  end else if (c >= "a" && c <= "f") begin
    d = c - 8'h57;
  end else if (c >= "A" && c <= "F") begin
    d = c - 8'h37;
  end else begin
    return 5'd0;
  end
  return {1'b1, d[3:0]};
endfunction

class form_decode_model;
  fx_result_t awaited_chars[$];
  logic       sel_mode;
  logic [63:0] key_text;
  logic [3:0] key_len;
  logic       no_newline;
  logic [fufe_pkg::PHASE_W-1:0] ph;
  logic [3:0] match_pos;
  logic [3:0] high_nib;
  int         n_checked;
  int         n_flagged;
  int         n_fails;

  function new();
    sel_mode = 1'b0;
    key_text = 64'd0;
    key_len = 4'd0;
    no_newline = 1'b0;
    n_checked = 0;
    n_flagged = 0;
    n_fails = 0;
    restart();
  endfunction

  function void restart();
    ph = fufe_pkg::PH_HEAD;
    match_pos = 4'd0;
    high_nib = 4'd0;
  endfunction

  function void set_reg(input logic [1:0] idx, input logic [63:0] val);
    case (idx)
      fufe_pkg::REG_SELECT_MODE: sel_mode = val[0];
      fufe_pkg::REG_KEY_TEXT:    key_text = val;
      fufe_pkg::REG_KEY_LENGTH:  key_len = val[3:0];
      fufe_pkg::REG_SUPPRESS_NL: no_newline = val[0];
      default: ;
    endcase
  endfunction

  function int pending();
    return awaited_chars.size();
  endfunction

  function void take_request(input logic kind, input logic [7:0] b);
    fx_result_t r;
    logic       emit;
    logic [4:0] hv;
    int         eff;
    r = '0;
    emit = 1'b0;
    eff = (key_len > fufe_pkg::MAX_KEY_BYTES) ? fufe_pkg::MAX_KEY_BYTES : int'(key_len);
    if (kind) begin
      emit = 1'b1;
      r.stream_end = 1'b1;
      if (ph == fufe_pkg::PH_HALT) begin
        r.error_code = fufe_pkg::ERR_NONE;
      end else if (ph == fufe_pkg::PH_ESC1 || ph == fufe_pkg::PH_ESC2 ||
                   ph == fufe_pkg::PH_ESC2_BAD) begin
        r.error_code = fufe_pkg::ERR_CUT;
      end else if (sel_mode ? !no_newline : ph == fufe_pkg::PH_VALUE) begin
        r.has_byte = 1'b1;
        r.out_byte = fufe_pkg::CH_NL;
      end
      restart();
    end else begin
      case (ph)
        fufe_pkg::PH_HEAD: begin
          if (!sel_mode) begin
            emit = 1'b1;
            r.has_byte = 1'b1;
            r.out_byte = b;
            if (b == fufe_pkg::CH_EQUAL) ph = fufe_pkg::PH_VALUE;
          end else if (match_pos < eff) begin
            if (b == key_text[8*match_pos +: 8]) begin
              match_pos = match_pos + 4'd1;
            end else if (b == fufe_pkg::CH_AMP) begin
              match_pos = 4'd0;
            end else begin
              match_pos = 4'd0;
              ph = fufe_pkg::PH_SKIP;
            end
          end else begin
            match_pos = 4'd0;
            if (b == fufe_pkg::CH_EQUAL) ph = fufe_pkg::PH_VALUE;
            else if (b != fufe_pkg::CH_AMP) ph = fufe_pkg::PH_SKIP;
          end
        end
        fufe_pkg::PH_SKIP: begin
          if (b == fufe_pkg::CH_AMP) begin
            ph = fufe_pkg::PH_HEAD;
            match_pos = 4'd0;
          end
        end
        fufe_pkg::PH_VALUE: begin
          if (b == fufe_pkg::CH_AMP) begin
            if (sel_mode) begin
              ph = fufe_pkg::PH_DONE;
            end else begin
              ph = fufe_pkg::PH_HEAD;
              match_pos = 4'd0;
              emit = 1'b1;
              r.has_byte = 1'b1;
              r.out_byte = fufe_pkg::CH_NL;
            end
          end else if (b == fufe_pkg::CH_PERCENT) begin
            ph = fufe_pkg::PH_ESC1;
          end else begin
            emit = 1'b1;
            r.has_byte = 1'b1;
            r.out_byte = (b == fufe_pkg::CH_PLUS) ? fufe_pkg::CH_SPACE : b;
          end
        end
        fufe_pkg::PH_ESC1: begin
          hv = hex_nibble(b);
          high_nib = hv[4] ? hv[3:0] : 4'd0;
          ph = hv[4] ? fufe_pkg::PH_ESC2 : fufe_pkg::PH_ESC2_BAD;
        end
        fufe_pkg::PH_ESC2: begin
          hv = hex_nibble(b);
          emit = 1'b1;
          if (hv[4]) begin
            r.has_byte = 1'b1;
            r.out_byte = {high_nib, hv[3:0]};
            ph = fufe_pkg::PH_VALUE;
          end else begin
            r.error_code = fufe_pkg::ERR_BAD_HEX;
            ph = fufe_pkg::PH_HALT;
          end
          high_nib = 4'd0;
        end
        fufe_pkg::PH_ESC2_BAD: begin
          emit = 1'b1;
          r.error_code = fufe_pkg::ERR_BAD_HEX;
          high_nib = 4'd0;
          ph = fufe_pkg::PH_HALT;
        end
        default: ;
      endcase
    end
    if (emit) awaited_chars.push_back(r);
  endfunction

  function void match_result(input fx_result_t got);
    fx_result_t exp;
    n_checked++;
    if (got.error_code != fufe_pkg::ERR_NONE) n_flagged++;
    if (awaited_chars.size() == 0) begin
      $error("result with nothing awaited: has_byte %0d out_byte %02h end %0d err %0d",
             got.has_byte, got.out_byte, got.stream_end, got.error_code);
      n_fails++;
      return;
    end
    exp = awaited_chars.pop_front();
    if (got.has_byte !== exp.has_byte) begin
      $error("has_byte: expected %0d, got %0d", exp.has_byte, got.has_byte);
      n_fails++;
    end
    if (got.out_byte !== exp.out_byte) begin
      $error("out_byte: expected %02h, got %02h", exp.out_byte, got.out_byte);
      n_fails++;
    end
    if (got.stream_end !== exp.stream_end) begin
      $error("stream_end: expected %0d, got %0d", exp.stream_end, got.stream_end);
      n_fails++;
    end
    if (got.error_code !== exp.error_code) begin
      $error("error_code: expected %0d, got %0d", exp.error_code, got.error_code);
      n_fails++;
    end
  endfunction
endclass

module tb_form_urlencoded_field_extractor_core;

  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int BURST_ITEMS   = 100;
  localparam int PHASE_ITEMS   = 250;

  logic                         clk;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [fufe_pkg::ADDR_W-1:0]  paddr;
  logic [63:0]                  pwdata;
  logic [63:0]                  prdata;
  logic                         pready;

  fufe_in_if  din_if ();
  fufe_out_if dout_if ();

  form_urlencoded_field_extractor_core dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .din     (din_if),
    .dout    (dout_if)
  );

  form_decode_model model;

  logic [8:0]  req_q[$];
  logic [63:0] cur_key;
  logic [3:0]  cur_klen;
  logic        burst_only;
  logic        hold_req;
  int          sent_items;
  int          sent_ends;
  int          settings_run;
  int          rx_mode;
  int          rx_count;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    fx_result_t got;
    if (!rst && din_if.valid && din_if.ready) model.take_request(din_if.kind, din_if.in_byte);
    if (!rst && dout_if.valid && dout_if.ready) begin
      got.has_byte = dout_if.has_byte;
      got.out_byte = dout_if.out_byte;
      got.stream_end = dout_if.stream_end;
      got.error_code = dout_if.error_code;
      model.match_result(got);
    end
  end

  function automatic int pick_gap(input int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 2);
      default: return $urandom_range(0, 16);
    endcase
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin
    dout_if.ready = 1'b0;
    rx_mode = 0;
    rx_count = 0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      int stall;
      @(negedge clk);
      if (hold_req) begin
        dout_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        stall = pick_gap(rx_mode);
        if (stall > 0) begin
          dout_if.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      dout_if.ready <= 1'b1;
      do @(posedge clk); while (!(dout_if.valid && dout_if.ready));
      rx_count++;
      if (rx_count % 50 == 0) rx_mode = $urandom_range(0, 3);
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
    if (n < 4'd10) return "0" + 8'(n);
    return (upper ? "A" : "a") + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    logic [4:0] hv;
    do begin
      c = 8'($urandom_range(0, 255));
      hv = hex_nibble(c);
    end while (hv[4]);
    return c;
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    req_q.push_back({1'b0, b});
  endfunction

  function automatic void push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic void push_end();
    req_q.push_back({1'b1, 8'($urandom_range(0, 255))});
  endfunction

  function automatic logic [7:0] key_letter();
    return 8'($urandom_range(8'h61, 8'h68));
  endfunction

  function automatic logic [7:0] rand_hex_char();
    return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endfunction

  function automatic void push_value_piece();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      push_byte(8'($urandom_range(8'h30, 8'h7A)));
    end else if (r < 60) begin
      push_byte(fufe_pkg::CH_PLUS);
    end else if (r < 80) begin
      push_byte(fufe_pkg::CH_PERCENT);
      push_byte(rand_hex_char());
      push_byte(rand_hex_char());
    end else if (r < 82) begin
      // broken escape: bad first digit, or good first and bad second
      push_byte(fufe_pkg::CH_PERCENT);
      if ($urandom_range(0, 1) != 0) begin
        push_byte(non_hex());
        push_byte(8'($urandom_range(0, 255)));
      end else begin
        push_byte(rand_hex_char());
        push_byte(non_hex());
      end
    end else if (r < 85) begin
      push_byte(fufe_pkg::CH_EQUAL);
    end else begin
      push_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void build_stream();
    int eff, nf, f, i, r, n;
    eff = (cur_klen > fufe_pkg::MAX_KEY_BYTES) ? fufe_pkg::MAX_KEY_BYTES : int'(cur_klen);
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 12);
      for (i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
      push_end();
      return;
    end
    nf = $urandom_range(1, 4);
    for (f = 0; f < nf; f++) begin
      if (f > 0) push_byte(fufe_pkg::CH_AMP);
      r = $urandom_range(0, 9);
      if (r < 4) begin
        for (i = 0; i < eff; i++) push_byte(cur_key[8*i +: 8]);
      end else if (r == 4) begin
        n = $urandom_range(0, eff);
        for (i = 0; i < n; i++) push_byte(cur_key[8*i +: 8]);
        push_byte(key_letter());
      end else begin
        n = $urandom_range(0, 5);
        for (i = 0; i < n; i++) push_byte(key_letter());
      end
      if ($urandom_range(0, 9) != 0) push_byte(fufe_pkg::CH_EQUAL);
      n = $urandom_range(0, 8);
      for (i = 0; i < n; i++) push_value_piece();
    end
    r = $urandom_range(0, 19);
    if (r < 2) push_byte(fufe_pkg::CH_PERCENT);
    if (r == 1) push_byte(rand_hex_char());
    push_end();
  endfunction

  task automatic send_item(input logic kind, input logic [7:0] b, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      din_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    din_if.valid <= 1'b1;
    din_if.kind <= kind;
    din_if.in_byte <= b;
    do @(posedge clk); while (!din_if.ready);
    sent_items++;
    if (kind) sent_ends++;
  endtask

  task automatic send_stream();
    logic [8:0] item;
    int mode;
    mode = $urandom_range(0, 3);
    while (req_q.size() != 0) begin
      item = req_q.pop_front();
      send_item(item[8], item[7:0], burst_only ? 0 : pick_gap(mode));
    end
  endtask

  // drop valid and hold until every predicted result has come out
  task automatic wait_drained();
    @(negedge clk);
    din_if.valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    model.set_reg(idx, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_setting(input logic sel, input logic [63:0] kt, input logic [3:0] kl,
                             input logic sup, input logic hold_first, input logic pause_mid);
    int start;
    logic paused;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    reg_write(fufe_pkg::REG_SELECT_MODE, {63'd0, sel});
    reg_write(fufe_pkg::REG_KEY_TEXT, kt);
    reg_write(fufe_pkg::REG_KEY_LENGTH, {60'd0, kl});
    reg_write(fufe_pkg::REG_SUPPRESS_NL, {63'd0, sup});
    cur_key = kt;
    cur_klen = kl;
    settings_run++;
    start = sent_items;
    paused = 1'b0;
    if (hold_first) begin
      hold_req = 1'b1;
      burst_only = 1'b1;
    end
    while (sent_items - start < PHASE_ITEMS) begin
      if (burst_only && sent_items - start >= BURST_ITEMS) burst_only = 1'b0;
      if (pause_mid && !paused && sent_items - start >= PHASE_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      build_stream();
      send_stream();
    end
  endtask

  function automatic logic [63:0] random_key();
    logic [63:0] k;
    int i;
    for (i = 0; i < 8; i++) k[8*i +: 8] = key_letter();
    return k;
  endfunction

  initial begin
    model = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    din_if.valid = 1'b0;
    din_if.kind = 1'b0;
    din_if.in_byte = 8'd0;
    hold_req = 1'b0;
    burst_only = 1'b0;
    sent_items = 0;
    sent_ends = 0;
    settings_run = 1;
    cur_key = 64'd0;
    cur_klen = 4'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // dump mode after reset: raw key bytes, '+', escapes of both cases, byte extremes,
    // key cut before '=', escape cut after '%' and after one digit, bad hex then halt
    push_byte(8'h00);
    push_text("=%4a+%7E&");
    push_byte(8'hFF);
    push_end();
    push_text("=%");
    push_end();
    push_text("q=%g1z");
    push_end();
    push_text("a=%4");
    push_end();
    send_stream();

    run_setting(1'b0, random_key(), 4'd3, 1'b1, 1'b1, 1'b0);
    run_setting(1'b1, random_key(), 4'($urandom_range(1, 7)), 1'b0, 1'b0, 1'b1);
    run_setting(1'b1, random_key(), 4'd0, 1'b1, 1'b0, 1'b0);
    run_setting(1'b1, random_key(), 4'd8, 1'b0, 1'b0, 1'b0);
    run_setting(1'b1, random_key(), 4'd15, 1'b1, 1'b0, 1'b0);
    run_setting(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 1'b0, 1'b0);
    run_setting(1'b0, 64'd0, 4'd0, 1'b0, 1'b0, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Drove %0d requests in %0d streams under %0d register settings.",
             sent_items, sent_ends, settings_run);
    $display("Checked %0d results, %0d of them carrying an error code.",
             model.n_checked, model.n_flagged);
    if (model.n_fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
